@@ hw/rtl/ptc_pkg.sv @@
// Shared types, constants and helpers for the pressure/temperature compensation pipeline.
package ptc_pkg;

  localparam int RAW_W     = 24;
  localparam int CAL_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 32;
  localparam int TEMP_W    = 20;
  localparam int ACC_W     = 40;
  localparam int T2_W      = 17;
  localparam int WIDE_W    = 48;

  // Register indexes of the calibration port
  localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

  // Temperature thresholds in 0.01 degC
  localparam logic signed [TEMP_W-1:0] T_REF  = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] T_COLD = -20'sd1500;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // First-order results
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp1;
    logic signed [ACC_W-1:0]  off1;
    logic signed [ACC_W-1:0]  sens1;
    logic [T2_W-1:0]          t2;
  } first_t;

  // Results after the second-order correction
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [ACC_W-1:0]  off;
    logic signed [ACC_W-1:0]  sens;
  } corr_t;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    lo = {{(WIDE_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    if (v > hi) begin
      sat32 = hi[OUT_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[OUT_W-1:0];
    end else begin
      sat32 = v[OUT_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/ptc_in_if.sv @@
// Sample channel: raw pressure and temperature converter words.
interface ptc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ptc_pkg::RAW_W-1:0]  pressure_raw;
  logic [ptc_pkg::RAW_W-1:0]  temperature_raw;

  modport source (output valid, output pressure_raw, output temperature_raw, input ready);
  modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

@@ hw/rtl/ptc_out_if.sv @@
// Result channel: compensated temperature and pressure.
interface ptc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ptc_pkg::OUT_W-1:0]  temperature_centi_c;
  logic signed [ptc_pkg::OUT_W-1:0]  pressure_centi_mbar;

  modport source (output valid, output temperature_centi_c, output pressure_centi_mbar,
                  input ready);
  modport sink   (input valid, input temperature_centi_c, input pressure_centi_mbar,
                  output ready);
endinterface

@@ hw/rtl/ptc_front.sv @@
// First-order compensation: dT, the coefficient products and TEMP, OFF, SENS, T2.
module ptc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ptc_pkg::RAW_W-1:0] pressure_raw,
  input  logic [ptc_pkg::RAW_W-1:0] temperature_raw,
  input  ptc_pkg::cal_t             cal,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ptc_pkg::first_t           out_data
);
  import ptc_pkg::*;

  logic [2:0] v;
  logic [2:0] adv;

  assign adv[2]    = !v[2] || out_ready;
  assign adv[1]    = !v[1] || adv[2];
  assign adv[0]    = !v[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
    end
  end

  // Stage 0: dT = D2 - C5 * 256
  logic signed [24:0]     dt_next;
  logic signed [24:0]     dt;
  logic [RAW_W-1:0]       d1_s0;

  assign dt_next = $signed({1'b0, temperature_raw}) - $signed({1'b0, cal.c5, 8'h00});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dt    <= dt_next;
      d1_s0 <= pressure_raw;
    end
  end

  // Stage 1: coefficient products and dT squared
  logic signed [16:0] c3s;
  logic signed [16:0] c4s;
  logic signed [16:0] c6s;
  logic signed [41:0] p_t_next;
  logic signed [41:0] p_off_next;
  logic signed [41:0] p_sens_next;
  logic signed [49:0] p_sq_next;
  logic signed [41:0] p_t;
  logic signed [41:0] p_off;
  logic signed [41:0] p_sens;
  logic signed [49:0] p_sq;
  logic [RAW_W-1:0]   d1_s1;

  assign c3s         = $signed({1'b0, cal.c3});
  assign c4s         = $signed({1'b0, cal.c4});
  assign c6s         = $signed({1'b0, cal.c6});
  assign p_t_next    = dt * c6s;
  assign p_off_next  = dt * c4s;
  assign p_sens_next = dt * c3s;
  assign p_sq_next   = dt * dt;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p_t    <= p_t_next;
      p_off  <= p_off_next;
      p_sens <= p_sens_next;
      p_sq   <= p_sq_next;
      d1_s1  <= d1_s0;
    end
  end

  // Stage 2: scale with truncation toward zero (bias negative values before the shift)
  logic signed [41:0] t_adj;
  logic signed [41:0] off_adj;
  logic signed [41:0] sens_adj;
  logic signed [41:0] t_sh;
  logic signed [41:0] off_sh;
  logic signed [41:0] sens_sh;
  logic [49:0]        sq_sh;
  first_t             first_next;

  assign t_adj    = p_t + (p_t[41] ? 42'sd8388607 : 42'sd0);
  assign off_adj  = p_off + (p_off[41] ? 42'sd127 : 42'sd0);
  assign sens_adj = p_sens + (p_sens[41] ? 42'sd255 : 42'sd0);
  assign t_sh     = t_adj >>> 23;
  assign off_sh   = off_adj >>> 7;
  assign sens_sh  = sens_adj >>> 8;
  assign sq_sh    = p_sq >> 31;

  always_comb begin
    first_next.d1    = d1_s1;
    first_next.temp1 = $signed(t_sh[TEMP_W-1:0]) + T_REF;
    first_next.off1  = $signed({8'h00, cal.c2, 16'h0000}) + $signed(off_sh[ACC_W-1:0]);
    first_next.sens1 = $signed({9'h000, cal.c1, 15'h0000}) + $signed(sens_sh[ACC_W-1:0]);
    first_next.t2    = sq_sh[T2_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      out_data <= first_next;
    end
  end

endmodule

@@ hw/rtl/ptc_second.sv @@
// Second-order correction below 20 degC, with the extra cold term below -15 degC.
module ptc_second (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ptc_pkg::first_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ptc_pkg::corr_t  out_data
);
  import ptc_pkg::*;

  logic [2:0] v;
  logic [2:0] adv;

  assign adv[2]    = !v[2] || out_ready;
  assign adv[1]    = !v[1] || adv[2];
  assign adv[0]    = !v[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
    end
  end

  // Stage 0: squares of the distances to both thresholds
  logic signed [20:0] a_next;
  logic signed [20:0] b_next;
  logic signed [41:0] aa_full;
  logic signed [41:0] bb_full;
  logic [35:0]        aa;
  logic [35:0]        bb;
  logic               lt20_s0;
  logic               lt15_s0;
  first_t             f_s0;

  assign a_next  = 21'(in_data.temp1) - 21'(T_REF);
  assign b_next  = 21'(in_data.temp1) - 21'(T_COLD);
  assign aa_full = a_next * a_next;
  assign bb_full = b_next * b_next;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      aa      <= aa_full[35:0];
      bb      <= bb_full[35:0];
      lt20_s0 <= in_data.temp1 < T_REF;
      lt15_s0 <= in_data.temp1 < T_COLD;
      f_s0    <= in_data;
    end
  end

  // Stage 1: OFF2, SENS2 and T2, zero when warm
  logic [ACC_W-1:0] aa5;
  logic [ACC_W-1:0] bb7;
  logic [ACC_W-1:0] bb11;
  logic [ACC_W-1:0] off2_next;
  logic [ACC_W-1:0] sens2_next;
  logic [ACC_W-1:0] off2;
  logic [ACC_W-1:0] sens2;
  first_t           f_s1_next;
  first_t           f_s1;

  assign aa5  = ACC_W'(aa) * 40'd5;
  assign bb7  = ACC_W'(bb) * 40'd7;
  assign bb11 = ACC_W'(bb) * 40'd11;

  always_comb begin
    off2_next  = '0;
    sens2_next = '0;
    if (lt20_s0) begin
      off2_next  = aa5 >> 1;
      sens2_next = aa5 >> 2;
      if (lt15_s0) begin
        off2_next  = off2_next + bb7;
        sens2_next = sens2_next + (bb11 >> 1);
      end
    end
  end

  always_comb begin
    f_s1_next    = f_s0;
    f_s1_next.t2 = lt20_s0 ? f_s0.t2 : '0;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      off2  <= off2_next;
      sens2 <= sens2_next;
      f_s1  <= f_s1_next;
    end
  end

  // Stage 2: apply the corrections
  logic [ACC_W:0]    off_wide;
  logic [ACC_W:0]    sens_wide;
  logic [TEMP_W-1:0] temp_diff;
  corr_t             corr_next;

  assign off_wide  = {f_s1.off1[ACC_W-1], f_s1.off1} - {1'b0, off2};
  assign sens_wide = {f_s1.sens1[ACC_W-1], f_s1.sens1} - {1'b0, sens2};
  assign temp_diff = f_s1.temp1 - {3'b000, f_s1.t2};

  always_comb begin
    corr_next.d1   = f_s1.d1;
    corr_next.temp = $signed(temp_diff);
    corr_next.off  = $signed(off_wide[ACC_W-1:0]);
    corr_next.sens = $signed(sens_wide[ACC_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      out_data <= corr_next;
    end
  end

endmodule

@@ hw/rtl/ptc_pres.sv @@
// Pressure: split D1 * SENS product, scaling, OFF subtract and saturation to 32 bits.
module ptc_pres (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ptc_pkg::corr_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [ptc_pkg::OUT_W-1:0] temperature_centi_c,
  output logic signed [ptc_pkg::OUT_W-1:0] pressure_centi_mbar
);
  import ptc_pkg::*;

  logic [3:0] v;
  logic [3:0] adv;

  assign adv[3]    = !v[3] || out_ready;
  assign adv[2]    = !v[2] || adv[3];
  assign adv[1]    = !v[1] || adv[2];
  assign adv[0]    = !v[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
      if (adv[3]) v[3] <= v[2];
    end
  end

  // Stage 0: D1 times the low and high halves of SENS
  logic [43:0]              p_lo_next;
  logic signed [44:0]       p_hi_next;
  logic [43:0]              p_lo;
  logic signed [44:0]       p_hi;
  logic                     neg_s0;
  logic signed [ACC_W-1:0]  off_s0;
  logic signed [TEMP_W-1:0] temp_s0;

  assign p_lo_next = in_data.d1 * in_data.sens[19:0];
  assign p_hi_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[ACC_W-1:20]);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_lo    <= p_lo_next;
      p_hi    <= p_hi_next;
      // the product is negative exactly when SENS is negative and D1 is nonzero
      neg_s0  <= in_data.sens[ACC_W-1] && (in_data.d1 != '0);
      off_s0  <= in_data.off;
      temp_s0 <= in_data.temp;
    end
  end

  // Stage 1: recombine, with the round-toward-zero bias for the divide by 2^21
  logic signed [65:0]       prod_next;
  logic signed [65:0]       prod;
  logic signed [ACC_W-1:0]  off_s1;
  logic signed [TEMP_W-1:0] temp_s1;

  assign prod_next = $signed({p_hi[44], p_hi, 20'h00000}) + $signed({22'h000000, p_lo})
                   + (neg_s0 ? 66'sd2097151 : 66'sd0);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prod    <= prod_next;
      off_s1  <= off_s0;
      temp_s1 <= temp_s0;
    end
  end

  // Stage 2: scale and subtract OFF
  logic signed [65:0]       q_full;
  logic signed [WIDE_W-1:0] x_next;
  logic signed [WIDE_W-1:0] x;
  logic signed [TEMP_W-1:0] temp_s2;

  assign q_full = prod >>> 21;
  assign x_next = $signed(q_full[WIDE_W-1:0])
                - $signed({{(WIDE_W-ACC_W){off_s1[ACC_W-1]}}, off_s1});

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      x       <= x_next;
      temp_s2 <= temp_s1;
    end
  end

  // Stage 3: divide by 2^15 toward zero, clamp, hold for the sink
  logic signed [WIDE_W-1:0] x_adj;
  logic signed [WIDE_W-1:0] pres_wide;

  assign x_adj     = x + (x[WIDE_W-1] ? 48'sd32767 : 48'sd0);
  assign pres_wide = x_adj >>> 15;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      pressure_centi_mbar <= sat32(pres_wide);
      temperature_centi_c <= sat32({{(WIDE_W-TEMP_W){temp_s2[TEMP_W-1]}}, temp_s2});
    end
  end

endmodule

@@ hw/rtl/pressure_temperature_compensation_unit.sv @@
// Compensated pressure and temperature from two raw converter words and six calibration words.
//
// Each sample beat carries raw pressure D1 and raw temperature D2; each result beat returns
// temperature in 0.01 degC and pressure in 0.01 mbar, both clamped to signed 32 bits, with
// first-order compensation plus the second-order correction below 20.00 degC and the extra
// term below -15.00 degC. Divisions round toward zero. The datapath is a ten-stage pipeline
// (three stages first order, three stages second order, four stages for the D1 * SENS product
// and pressure scaling) that takes one sample per cycle until a stalled result fills it. Every
// stage holds its own valid bit, so samples keep entering while a result waits at the output;
// backpressure reaches the sample side only once all ten stages are full. Calibration words
// are written through cfg_wr_en / cfg_index / cfg_data, reset to zero, and must be written
// only while the pipeline is empty; writes to indexes six and seven are dropped.
module pressure_temperature_compensation_unit (
  input  logic                          clk,
  input  logic                          rst,
  ptc_in_if.sink                        sample,
  ptc_out_if.source                     result,
  input  logic                          cfg_wr_en,
  input  logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptc_pkg::CAL_W-1:0]     cfg_data
);
  import ptc_pkg::*;

  cal_t cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_C1:  cal.c1 <= cfg_data;
        REG_C2:  cal.c2 <= cfg_data;
        REG_C3:  cal.c3 <= cfg_data;
        REG_C4:  cal.c4 <= cfg_data;
        REG_C5:  cal.c5 <= cfg_data;
        REG_C6:  cal.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic   first_valid;
  logic   first_ready;
  first_t first_data;
  logic   corr_valid;
  logic   corr_ready;
  corr_t  corr_data;

  ptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (sample.valid),
    .in_ready        (sample.ready),
    .pressure_raw    (sample.pressure_raw),
    .temperature_raw (sample.temperature_raw),
    .cal             (cal),
    .out_valid       (first_valid),
    .out_ready       (first_ready),
    .out_data        (first_data)
  );

  ptc_second u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (first_valid),
    .in_ready  (first_ready),
    .in_data   (first_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  ptc_pres u_pres (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (corr_valid),
    .in_ready            (corr_ready),
    .in_data             (corr_data),
    .out_valid           (result.valid),
    .out_ready           (result.ready),
    .temperature_centi_c (result.temperature_centi_c),
    .pressure_centi_mbar (result.pressure_centi_mbar)
  );

endmodule
